// ===== hdl/rcf_pkg.sv =====
package rcf_pkg;

  // ascii codes the framer looks for
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  // result codes
  localparam logic       EV_COMMAND = 1'b0;
  localparam logic       EV_ERROR   = 1'b1;
  localparam logic [1:0] CLS_OTHER   = 2'd0;
  localparam logic [1:0] CLS_WRITE   = 2'd1;
  localparam logic [1:0] CLS_SYNC    = 2'd2;
  localparam logic [1:0] CLS_FINSYNC = 2'd3;

  // register indexes on the apb port
  localparam logic [1:0] REG_MAX_ARGC    = 2'd0;
  localparam logic [1:0] REG_MAX_BULK    = 2'd1;
  localparam logic [1:0] REG_MAX_COMMAND = 2'd2;

  localparam logic [15:0] MAX_ARGC_RST    = 16'd1024;
  localparam logic [23:0] MAX_BULK_RST    = 24'd8388608;
  localparam logic [23:0] MAX_COMMAND_RST = 24'd8388608;

  typedef struct packed {
    logic [15:0] max_argc;
    logic [23:0] max_bulk_len;
    logic [23:0] max_command_len;
  } cfg_t;

  // one classified input byte
  typedef struct packed {
    logic [7:0] data_upper;
    logic [3:0] digit;
    logic       is_digit;
    logic       is_star;
    logic       is_dollar;
    logic       is_cr;
    logic       is_lf;
    logic       seg_end;
    logic       start_over;
  } beat_t;

  typedef struct packed {
    logic        event_kind;
    logic [23:0] command_length;
    logic [1:0]  command_class;
  } res_t;

  // first eight name characters, char 0 in the top byte, unused bytes zero
  function automatic logic [1:0] name_class(input logic [3:0] len, input logic [63:0] word);
    logic [1:0] cls;
    cls = CLS_OTHER;
    case (word)
      {"SYNC", 32'd0}:    if (len == 4'd4) cls = CLS_SYNC;
      {"FINSYNC", 8'd0}:  if (len == 4'd7) cls = CLS_FINSYNC;
      {"SET", 40'd0}:     if (len == 4'd3) cls = CLS_WRITE;
      {"RSET", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"HSET", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"SKSET", 24'd0}:   if (len == 4'd5) cls = CLS_WRITE;
      {"DEL", 40'd0}:     if (len == 4'd3) cls = CLS_WRITE;
      {"RDEL", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"HDEL", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"SKDEL", 24'd0}:   if (len == 4'd5) cls = CLS_WRITE;
      {"MOD", 40'd0}:     if (len == 4'd3) cls = CLS_WRITE;
      {"RMOD", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"HMOD", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      {"SKMOD", 24'd0}:   if (len == 4'd5) cls = CLS_WRITE;
      {"EXPIRE", 16'd0}:  if (len == 4'd6) cls = CLS_WRITE;
      {"REXPIRE", 8'd0}:  if (len == 4'd7) cls = CLS_WRITE;
      {"HEXPIRE", 8'd0}:  if (len == 4'd7) cls = CLS_WRITE;
      64'("SKEXPIRE"):    if (len == 4'd8) cls = CLS_WRITE;
      {"SETEX", 24'd0}:   if (len == 4'd5) cls = CLS_WRITE;
      {"RSETEX", 16'd0}:  if (len == 4'd6) cls = CLS_WRITE;
      {"HSETEX", 16'd0}:  if (len == 4'd6) cls = CLS_WRITE;
      {"SKSETEX", 8'd0}:  if (len == 4'd7) cls = CLS_WRITE;
      {"VSET", 32'd0}:    if (len == 4'd4) cls = CLS_WRITE;
      default:            cls = CLS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ===== hdl/rcf_fifo.sv =====
module rcf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hdl/rcf_front.sv =====
module rcf_front (
  input  logic          push,
  output logic          full,
  input  logic [7:0]    data_byte,
  input  logic          segment_end,
  input  logic          start_over,
  output logic          q_push,
  output rcf_pkg::beat_t q_beat,
  input  logic          q_full
);

  import rcf_pkg::*;

  logic is_lower;

  assign full     = q_full;
  assign q_push   = push && !q_full;
  assign is_lower = (data_byte >= CH_LOW_A) && (data_byte <= CH_LOW_Z);

  // byte classes decoded once here so the parser sees flags, the digit value and the upper-cased byte
  always_comb begin
    q_beat.data_upper = is_lower ? (data_byte - CASE_DIFF) : data_byte;
    q_beat.digit      = data_byte[3:0];
    q_beat.is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    q_beat.is_star    = (data_byte == CH_STAR);
    q_beat.is_dollar  = (data_byte == CH_DOLLAR);
    q_beat.is_cr      = (data_byte == CH_CR);
    q_beat.is_lf      = (data_byte == CH_LF);
    q_beat.seg_end    = segment_end;
    q_beat.start_over = start_over;
  end

endmodule

// ===== hdl/rcf_back.sv =====
module rcf_back #(
  parameter int NAME_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rcf_pkg::cfg_t  cfg,
  input  rcf_pkg::beat_t q_beat,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           res_full,
  output logic           res_push,
  output rcf_pkg::res_t  res
);

  import rcf_pkg::*;

  localparam int NL_W = $clog2(NAME_BYTES + 2);

  localparam logic [3:0] PH_STAR    = 4'd0;
  localparam logic [3:0] PH_ARGC_D0 = 4'd1;
  localparam logic [3:0] PH_ARGC_D  = 4'd2;
  localparam logic [3:0] PH_ARGC_LF = 4'd3;
  localparam logic [3:0] PH_DOLLAR  = 4'd4;
  localparam logic [3:0] PH_LEN_D0  = 4'd5;
  localparam logic [3:0] PH_LEN_D   = 4'd6;
  localparam logic [3:0] PH_LEN_LF  = 4'd7;
  localparam logic [3:0] PH_DATA    = 4'd8;
  localparam logic [3:0] PH_DATA_CR = 4'd9;
  localparam logic [3:0] PH_DATA_LF = 4'd10;

  logic [3:0]      phase_r, phase_nxt, eff_phase;
  logic [27:0]     num_r, num_nxt, eff_num;
  logic [15:0]     args_r, args_nxt, eff_args;
  logic [23:0]     bulk_r, bulk_nxt, eff_bulk;
  logic [23:0]     bytes_r, bytes_nxt, eff_bytes;
  logic [7:0]      name_r [NAME_BYTES];
  logic [7:0]      name_nxt [NAME_BYTES];
  logic [7:0]      eff_name [NAME_BYTES];
  logic [NL_W-1:0] nlen_r, nlen_nxt, eff_nlen;
  logic            first_r, first_nxt, eff_first;
  logic            disc_r, disc_nxt;

  logic [24:0]     count;
  logic [27:0]     num10;
  logic            digit_ok;
  logic            fail;
  logic [63:0]     name_word;
  logic [1:0]      cls;

  assign q_pop = !q_empty && !res_full;
  assign count = {1'b0, eff_bytes} + 25'd1;
  assign num10 = {eff_num[24:0], 3'b000} + {eff_num[26:0], 1'b0} + {24'd0, q_beat.digit};
  assign digit_ok = q_beat.is_digit && (num10 <= {4'd0, cfg.max_bulk_len});

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      name_word[63 - 8*i -: 8] = eff_name[i];
    end
    if (eff_nlen > NL_W'(8)) begin
      cls = CLS_OTHER;
    end else begin
      cls = name_class(4'(eff_nlen), name_word);
    end
  end

  always_comb begin
    // start over clears the partial command ahead of this byte
    if (q_beat.start_over) begin
      eff_phase = PH_STAR;
      eff_num   = '0;
      eff_args  = '0;
      eff_bulk  = '0;
      eff_bytes = '0;
      eff_nlen  = '0;
      eff_first = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) eff_name[i] = '0;
    end else begin
      eff_phase = phase_r;
      eff_num   = num_r;
      eff_args  = args_r;
      eff_bulk  = bulk_r;
      eff_bytes = bytes_r;
      eff_nlen  = nlen_r;
      eff_first = first_r;
      for (int i = 0; i < NAME_BYTES; i++) eff_name[i] = name_r[i];
    end

    phase_nxt = eff_phase;
    num_nxt   = eff_num;
    args_nxt  = eff_args;
    bulk_nxt  = eff_bulk;
    bytes_nxt = eff_bytes;
    nlen_nxt  = eff_nlen;
    first_nxt = eff_first;
    for (int i = 0; i < NAME_BYTES; i++) name_nxt[i] = eff_name[i];
    disc_nxt  = disc_r && !q_beat.start_over;
    fail      = 1'b0;
    res_push  = 1'b0;
    res       = '0;

    if (disc_nxt) begin
      if (q_beat.seg_end) disc_nxt = 1'b0;
    end else if (count > {1'b0, cfg.max_command_len}) begin
      fail = 1'b1;
    end else begin
      bytes_nxt = count[23:0];
      unique case (eff_phase)
        PH_STAR: begin
          if (!q_beat.is_star) fail = 1'b1;
          else begin
            num_nxt   = '0;
            phase_nxt = PH_ARGC_D0;
          end
        end
        PH_ARGC_D0, PH_LEN_D0: begin
          if (!digit_ok) fail = 1'b1;
          else begin
            num_nxt   = num10;
            phase_nxt = eff_phase + 4'd1;
          end
        end
        PH_ARGC_D, PH_LEN_D: begin
          if (q_beat.is_cr) phase_nxt = eff_phase + 4'd1;
          else if (!digit_ok) fail = 1'b1;
          else num_nxt = num10;
        end
        PH_ARGC_LF: begin
          if (!q_beat.is_lf || eff_num == '0 || eff_num > {12'd0, cfg.max_argc}) begin
            fail = 1'b1;
          end else begin
            args_nxt  = eff_num[15:0];
            first_nxt = 1'b1;
            phase_nxt = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (!q_beat.is_dollar) fail = 1'b1;
          else begin
            num_nxt   = '0;
            phase_nxt = PH_LEN_D0;
          end
        end
        PH_LEN_LF: begin
          if (!q_beat.is_lf) fail = 1'b1;
          else begin
            bulk_nxt  = eff_num[23:0];
            phase_nxt = (eff_num == '0) ? PH_DATA_CR : PH_DATA;
          end
        end
        PH_DATA: begin
          if (eff_first) begin
            if (eff_nlen < NL_W'(NAME_BYTES)) begin
              for (int i = 0; i < NAME_BYTES; i++) begin
                if (NL_W'(i) == eff_nlen) name_nxt[i] = q_beat.data_upper;
              end
              nlen_nxt = eff_nlen + 1'b1;
            end else begin
              nlen_nxt = NL_W'(NAME_BYTES + 1);
            end
          end
          bulk_nxt = eff_bulk - 24'd1;
          if (eff_bulk == 24'd1) phase_nxt = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (!q_beat.is_cr) fail = 1'b1;
          else phase_nxt = PH_DATA_LF;
        end
        PH_DATA_LF: begin
          if (!q_beat.is_lf) fail = 1'b1;
          else begin
            first_nxt = 1'b0;
            args_nxt  = eff_args - 16'd1;
            if (eff_args != 16'd1) begin
              phase_nxt = PH_DOLLAR;
            end else begin
              res_push           = 1'b1;
              res.event_kind     = EV_COMMAND;
              res.command_length = count[23:0];
              res.command_class  = cls;
              phase_nxt = PH_STAR;
              num_nxt   = '0;
              args_nxt  = '0;
              bulk_nxt  = '0;
              bytes_nxt = '0;
              nlen_nxt  = '0;
              first_nxt = 1'b0;
              for (int i = 0; i < NAME_BYTES; i++) name_nxt[i] = '0;
            end
          end
        end
        default: fail = 1'b1;
      endcase
    end

    if (fail) begin
      res_push       = 1'b1;
      res            = '0;
      res.event_kind = EV_ERROR;
      phase_nxt = PH_STAR;
      num_nxt   = '0;
      args_nxt  = '0;
      bulk_nxt  = '0;
      bytes_nxt = '0;
      nlen_nxt  = '0;
      first_nxt = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) name_nxt[i] = '0;
      disc_nxt  = !q_beat.seg_end;
    end

    if (!q_pop) res_push = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STAR;
      num_r   <= '0;
      args_r  <= '0;
      bulk_r  <= '0;
      bytes_r <= '0;
      nlen_r  <= '0;
      first_r <= 1'b0;
      disc_r  <= 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) name_r[i] <= '0;
    end else if (q_pop) begin
      phase_r <= phase_nxt;
      num_r   <= num_nxt;
      args_r  <= args_nxt;
      bulk_r  <= bulk_nxt;
      bytes_r <= bytes_nxt;
      nlen_r  <= nlen_nxt;
      first_r <= first_nxt;
      disc_r  <= disc_nxt;
      for (int i = 0; i < NAME_BYTES; i++) name_r[i] <= name_nxt[i];
    end
  end

endmodule

// ===== hdl/resp_command_framer_top.sv =====
// resp command framer: takes one byte of a flow's command stream per beat and frames
// it as resp arrays, giving one result beat for each completed command (length and
// class) or for each framing error, after which bytes are dropped to the end of the
// segment. the block sustains one byte per clock while the result queue has room: a
// front stage decodes each byte and pushes it into a small queue, and the parser behind
// it consumes one queued byte per cycle unless the result queue is full. a byte is
// registered in the byte queue and its result in the result queue before reaching the
// out ports. the rate is set by the parser's state update and by result queue space;
// full rises only when the byte queue fills, which needs the result queue to have
// filled while pop was low. limits are written through the apb port at byte addresses
// 0, 4 and 8; the user must write them only while idle; the block does not enforce it.
module resp_command_framer_top #(
  parameter int NAME_BYTES  = 8,
  parameter int IN_Q_DEPTH  = 4,
  parameter int OUT_Q_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input byte channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_segment_end,
  input  logic        in_start_over,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic        out_event_kind,
  output logic [23:0] out_command_length,
  output logic [1:0]  out_command_class,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import rcf_pkg::*;

  cfg_t  cfg_r;
  logic  cfg_wr;
  beat_t front_beat, q_beat;
  logic  front_push, q_full, q_empty, q_pop;
  res_t  back_res, out_res;
  logic  back_push, res_full;

  // apb registers, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_argc        <= MAX_ARGC_RST;
      cfg_r.max_bulk_len    <= MAX_BULK_RST;
      cfg_r.max_command_len <= MAX_COMMAND_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MAX_ARGC:    cfg_r.max_argc        <= pwdata[15:0];
        REG_MAX_BULK:    cfg_r.max_bulk_len    <= pwdata[23:0];
        REG_MAX_COMMAND: cfg_r.max_command_len <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_ARGC:    prdata = {16'd0, cfg_r.max_argc};
      REG_MAX_BULK:    prdata = {8'd0, cfg_r.max_bulk_len};
      REG_MAX_COMMAND: prdata = {8'd0, cfg_r.max_command_len};
      default:         prdata = '0;
    endcase
  end

  // front: accept and decode bytes
  rcf_front u_front (
    .push        (push),
    .full        (full),
    .data_byte   (in_data_byte),
    .segment_end (in_segment_end),
    .start_over  (in_start_over),
    .q_push      (front_push),
    .q_beat      (front_beat),
    .q_full      (q_full)
  );

  // decoupling queue between decode and parse
  rcf_fifo #(
    .WIDTH ($bits(beat_t)),
    .DEPTH (IN_Q_DEPTH)
  ) u_byte_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata (front_beat),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_beat),
    .empty (q_empty)
  );

  // back: resp parser, one byte per cycle while the result queue has room
  rcf_back #(
    .NAME_BYTES (NAME_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_beat   (q_beat),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (back_push),
    .res      (back_res)
  );

  // result queue keeps the parser moving while a result waits
  rcf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign out_event_kind     = out_res.event_kind;
  assign out_command_length = out_res.command_length;
  assign out_command_class  = out_res.command_class;

endmodule
